// ===== src/btps_pkg.sv =====
// Package for the battery trend and power-state core: field widths, codes, shared types.
// Depends on nothing; every other file uses it by scoped names.
`timescale 1ns / 1ps
package btps_pkg;
  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RATE_W = 22;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 15'd25600;
  localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
  localparam logic signed [RATE_W-1:0] RATE_LIMIT = 22'sd1536000;

  typedef enum logic [1:0] {
    PS_UNKNOWN = 2'd0, PS_CHARGING = 2'd1, PS_FULL = 2'd2, PS_DISCHARGING = 2'd3
  } pstate_t;

  typedef enum logic [2:0] {
    CFG_WINDOW = 3'd0, CFG_GAP = 3'd1, CFG_SPAN = 3'd2, CFG_CHG_TH = 3'd3,
    CFG_DIS_TH = 3'd4, CFG_STB_TH = 3'd5, CFG_FULL = 3'd6, CFG_DEB = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_MUL, ST_DIV, ST_OUT
  } fsm_t;

  // Control from the sequencer to the cell row.
  typedef struct packed {
    logic clear;
    logic push;
    logic shift;
  } chain_ctl_t;
endpackage

// ===== src/btps_if.sv =====
// Valid/ready channel interfaces for the input, result and configuration beats.
// Depends on btps_pkg.
`timescale 1ns / 1ps
interface btps_in_if;
  logic valid;
  logic ready;
  logic [15:0] soc_raw;
  logic [15:0] vcell_raw;
  logic [31:0] now_ms;
  modport source(output valid, soc_raw, vcell_raw, now_ms, input ready);
  modport sink(input valid, soc_raw, vcell_raw, now_ms, output ready);
endinterface

interface btps_out_if;
  logic valid;
  logic ready;
  logic [14:0] charge_level;
  logic [15:0] cell_voltage;
  logic signed [21:0] charge_rate;
  logic [1:0] power_state;
  logic external_power;
  modport source(output valid, charge_level, cell_voltage, charge_rate, power_state,
                 external_power, input ready);
  modport sink(input valid, charge_level, cell_voltage, charge_rate, power_state,
               external_power, output ready);
endinterface

interface btps_cfg_if;
  logic valid;
  logic ready;
  logic [btps_pkg::CFG_IDX_W-1:0] index;
  logic [btps_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/btps_cell.sv =====
// One history cell: holds a level, a time and a valid flag; loads its inputs on a push or a shift.
// Depends on btps_pkg.
`timescale 1ns / 1ps
module btps_cell (
  input  logic clk,
  input  logic rst_n,
  input  btps_pkg::chain_ctl_t ctl,
  input  logic                 in_vld,
  input  logic [btps_pkg::LEVEL_W-1:0] in_level,
  input  logic [btps_pkg::TIME_W-1:0]  in_time,
  output logic                 vld,
  output logic [btps_pkg::LEVEL_W-1:0] level,
  output logic [btps_pkg::TIME_W-1:0]  ts
);
  logic vld_r;
  logic [btps_pkg::LEVEL_W-1:0] level_r;
  logic [btps_pkg::TIME_W-1:0] ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.push || ctl.shift) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.shift) begin
      level_r <= in_level;
      ts_r <= in_time;
    end
  end

  assign vld = vld_r;
  assign level = level_r;
  assign ts = ts_r;
endmodule

// ===== src/btps_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned 44 by 32 bits.
// Depends on btps_pkg.
`timescale 1ns / 1ps
module btps_div (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [43:0] dividend,
  input  logic [btps_pkg::TIME_W-1:0] divisor,
  output logic busy,
  output logic [43:0] quotient
);
  logic [43:0] q_r;
  logic [32:0] rem_r;
  logic [btps_pkg::TIME_W-1:0] d_r;
  logic [5:0] cnt_r;
  logic busy_r;
  logic [32:0] trial;
  logic [33:0] diff;

  assign trial = {rem_r[31:0], q_r[43]};
  assign diff = {1'b0, trial} - {2'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= 6'd44;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      rem_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      if (!diff[33]) begin
        rem_r <= diff[32:0];
        q_r <= {q_r[42:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r <= {q_r[42:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quotient = q_r;
endmodule

// ===== src/battery_trend_power_state_core.sv =====
// Top level of the battery trend and power-state core: sequencer, cell row, divider.
// Depends on btps_pkg, btps_if, btps_cell and btps_div.
`timescale 1ns / 1ps
// One reading is taken at a time. Its level and timestamp are pushed into the newest end of a
// row of HISTORY_DEPTH cells. The row then rotates one place a cycle towards the newest end, so
// that the second cell sees the stored entries from one older than the newest down to the
// oldest. Each is compared with the window start, and the last entry that is inside the window
// is kept as the oldest. After HISTORY_DEPTH steps every entry is back where it was. The
// charge difference is then scaled by 3600000, and the product is loaded into a restoring
// divider that forms the rate. The next reading can be accepted from the cycle after the
// result has been taken, not before it. The result waits in an output register. No clearing
// pass is needed after reset: the cells carry valid flags. Configuration beats are always
// accepted and are to be sent only while idle.
module battery_trend_power_state_core #(
  parameter int unsigned HISTORY_DEPTH = 32
) (
  input logic clk,
  input logic rst_n,
  btps_in_if.sink    in_ch,
  btps_out_if.source out_ch,
  btps_cfg_if.sink   cfg_ch
);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  // Configuration registers.
  logic [31:0] win_r, gap_r, span_r;
  logic signed [21:0] chg_th_r, dis_th_r, stb_th_r;
  logic [14:0] full_r;
  logic [7:0] deb_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 32'd120000;
      gap_r <= 32'd90000;
      span_r <= 32'd60000;
      chg_th_r <= 22'sd384;
      dis_th_r <= -22'sd128;
      stb_th_r <= -22'sd26;
      full_r <= 15'd25344;
      deb_r <= 8'd2;
    end else if (cfg_ch.valid) begin
      unique case (btps_pkg::cfg_idx_t'(cfg_ch.index))
        btps_pkg::CFG_WINDOW: win_r <= cfg_ch.data;
        btps_pkg::CFG_GAP:    gap_r <= cfg_ch.data;
        btps_pkg::CFG_SPAN:   span_r <= cfg_ch.data;
        btps_pkg::CFG_CHG_TH: chg_th_r <= cfg_ch.data[21:0];
        btps_pkg::CFG_DIS_TH: dis_th_r <= cfg_ch.data[21:0];
        btps_pkg::CFG_STB_TH: stb_th_r <= cfg_ch.data[21:0];
        btps_pkg::CFG_FULL:   full_r <= cfg_ch.data[14:0];
        btps_pkg::CFG_DEB:    deb_r <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  btps_pkg::fsm_t state_r, state_nxt;
  btps_pkg::chain_ctl_t ctl;
  btps_pkg::chain_ctl_t cell_ctl;
  logic accept;
  logic [CW-1:0] walk_r;
  logic walk_done_r;
  logic [31:0] prev_r, nt_r, start_r, ot_r;
  logic [14:0] nl_r, ol_r, lvl_r;
  logic [15:0] volt_r;
  logic oldest_set_r;
  logic signed [15:0] diff_r;
  logic neg_r;
  logic div_start;
  logic div_busy;
  logic [43:0] quot;
  logic [1:0] last_raw_r, held_r;
  logic [7:0] rep_r;
  logic out_valid_r;
  logic signed [21:0] rate_r;

  // The cell row; cell 0 is the newest end.
  logic [HISTORY_DEPTH-1:0] c_vld;
  logic [14:0] c_lvl [HISTORY_DEPTH];
  logic [31:0] c_ts [HISTORY_DEPTH];
  logic [14:0] level_in;
  logic gap_clear;

  assign accept = in_ch.valid && in_ch.ready;
  assign level_in = (in_ch.soc_raw > {1'b0, btps_pkg::FULL_LEVEL}) ?
                    btps_pkg::FULL_LEVEL : in_ch.soc_raw[14:0];
  assign gap_clear = (prev_r != 32'd0) && (in_ch.now_ms > prev_r) &&
                     ((in_ch.now_ms - prev_r) > gap_r);

  // The cells never see the clear directly: the row drops old entries through its body
  // inputs, so that the head keeps the entry pushed in the same cycle.
  always_comb begin
    ctl.clear = accept && gap_clear;
    ctl.push = accept;
    ctl.shift = (state_r == btps_pkg::ST_WALK);
    cell_ctl.clear = 1'b0;
    cell_ctl.push = ctl.push;
    cell_ctl.shift = ctl.shift;
  end

  // On a push the row moves one place older; on a walk step it rotates one place towards the
  // newest end, so that after HISTORY_DEPTH steps every entry is back where it was.
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % HISTORY_DEPTH;
    logic v_in;
    logic [14:0] l_in;
    logic [31:0] t_in;
    if (i == 0) begin : g_head
      assign v_in = ctl.push ? 1'b1 : c_vld[NXT];
      assign l_in = ctl.push ? level_in : c_lvl[NXT];
      assign t_in = ctl.push ? in_ch.now_ms : c_ts[NXT];
    end else begin : g_body
      assign v_in = ctl.push ? (c_vld[i-1] && !ctl.clear) : c_vld[NXT];
      assign l_in = ctl.push ? c_lvl[i-1] : c_lvl[NXT];
      assign t_in = ctl.push ? c_ts[i-1] : c_ts[NXT];
    end
    btps_cell u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl(cell_ctl),
      .in_vld(v_in), .in_level(l_in), .in_time(t_in),
      .vld(c_vld[i]), .level(c_lvl[i]), .ts(c_ts[i])
    );
  end

  // The second cell's view as the row rotates: at walk step k it holds the entry k places older
  // than the newest. The walk stops extending at an invalid entry or one before the window start.
  logic probe_vld;
  logic [31:0] probe_ts;
  logic [14:0] probe_lvl;
  assign probe_vld = c_vld[1];
  assign probe_ts = c_ts[1];
  assign probe_lvl = c_lvl[1];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btps_pkg::ST_IDLE: if (accept) state_nxt = btps_pkg::ST_WALK;
      btps_pkg::ST_WALK: if (walk_r == CW'(HISTORY_DEPTH)) state_nxt = btps_pkg::ST_MUL;
      btps_pkg::ST_MUL:  state_nxt = btps_pkg::ST_DIV;
      btps_pkg::ST_DIV:  if (!div_busy) state_nxt = btps_pkg::ST_OUT;
      btps_pkg::ST_OUT:  if (out_valid_r && out_ch.ready) state_nxt = btps_pkg::ST_IDLE;
      default: state_nxt = btps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == btps_pkg::ST_IDLE);
    div_start = (state_r == btps_pkg::ST_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btps_pkg::ST_IDLE;
      prev_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) prev_r <= in_ch.now_ms;
    end
  end

  // Walk: on the first rotation step the second cell holds the entry one older than the newest.
  always_ff @(posedge clk) begin
    if (accept) begin
      walk_r <= CW'(1);
      walk_done_r <= 1'b0;
      oldest_set_r <= 1'b0;
      nt_r <= in_ch.now_ms;
      nl_r <= level_in;
      lvl_r <= level_in;
      volt_r <= in_ch.vcell_raw;
      start_r <= (in_ch.now_ms >= win_r) ? in_ch.now_ms - win_r : 32'd0;
    end else if (state_r == btps_pkg::ST_WALK) begin
      walk_r <= walk_r + CW'(1);
      if (!walk_done_r && walk_r < CW'(HISTORY_DEPTH)) begin
        if (!probe_vld || probe_ts < start_r) begin
          walk_done_r <= 1'b1;
        end else begin
          oldest_set_r <= 1'b1;
          ot_r <= probe_ts;
          ol_r <= probe_lvl;
        end
      end
    end
  end

  // A trend needs an older entry inside the window, time moving forward and a long enough span.
  logic trend_ok;
  logic [31:0] span;
  assign span = nt_r - ot_r;
  assign trend_ok = oldest_set_r && (nt_r > ot_r) && (span >= span_r);

  always_ff @(posedge clk) begin
    if (state_r == btps_pkg::ST_WALK && walk_r == CW'(HISTORY_DEPTH)) begin
      diff_r <= $signed({1'b0, nl_r}) - $signed({1'b0, ol_r});
    end
    if (state_r == btps_pkg::ST_MUL) begin
      neg_r <= diff_r[15];
    end
  end

  logic [15:0] mag;
  assign mag = diff_r[15] ? 16'(-diff_r) : 16'(diff_r);
  logic [43:0] prod_c;
  assign prod_c = 44'(mag) * 44'(btps_pkg::MS_PER_HOUR);

  btps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(prod_c), .divisor(span), .busy(div_busy), .quotient(quot)
  );

  logic signed [21:0] rate_c;
  logic [1:0] raw_c;
  always_comb begin
    logic signed [21:0] r;
    r = (quot > 44'(btps_pkg::RATE_LIMIT)) ? btps_pkg::RATE_LIMIT : 22'(quot);
    rate_c = !trend_ok ? 22'sd0 : (neg_r ? -r : r);
    priority if (trend_ok && rate_c > chg_th_r) raw_c = btps_pkg::PS_CHARGING;
    else if (lvl_r >= full_r && rate_c >= stb_th_r) raw_c = btps_pkg::PS_FULL;
    else if (!trend_ok) raw_c = btps_pkg::PS_UNKNOWN;
    else if (rate_c < dis_th_r) raw_c = btps_pkg::PS_DISCHARGING;
    else raw_c = btps_pkg::PS_UNKNOWN;
  end

  logic finish;
  logic [7:0] rep_c;
  assign finish = (state_r == btps_pkg::ST_DIV) && !div_busy;
  assign rep_c = (raw_c != last_raw_r) ? 8'd1 : ((rep_r == 8'd255) ? rep_r : rep_r + 8'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0;
      held_r <= '0;
      rep_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && gap_clear) begin
        last_raw_r <= '0;
        held_r <= '0;
        rep_r <= '0;
      end else if (finish) begin
        last_raw_r <= raw_c;
        rep_r <= rep_c;
        if (rep_c >= deb_r) held_r <= raw_c;
      end
      if (finish) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) rate_r <= rate_c;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.charge_level = lvl_r;
  assign out_ch.cell_voltage = volt_r;
  assign out_ch.charge_rate = rate_r;
  assign out_ch.power_state = held_r;
  assign out_ch.external_power = (held_r == btps_pkg::PS_CHARGING) ||
                                 (held_r == btps_pkg::PS_FULL);

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_valid_r) else $error("input taken while result pending");
  a_no_div_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !div_busy) else $error("divider busy with result shown");
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(rate_r)) else $error("rate moved");
`endif
endmodule

// ===== dv/btps_checker.sv =====
// Checker for the battery trend and power-state core: watches the configuration, reading and
// result channels, predicts each result and compares it field by field.
// Depends on btps_pkg and the channel interfaces in btps_if.
`timescale 1ns / 1ps
module btps_checker (
  input  logic       clk,
  input  logic       rst_n,
  btps_in_if         in_ch,
  btps_out_if        out_ch,
  btps_cfg_if        cfg_ch,
  output int         fail_count,
  output int         pending
);
  typedef struct packed {
    logic [14:0]        level;
    logic [15:0]        vcell;
    logic signed [21:0] rate;
    btps_pkg::pstate_t  pstate;
    logic               ext_pwr;
  } reading_result_t;

  // Register copies.
  logic [31:0] window_ms, gap_ms, span_min_ms;
  int          chg_th, dis_th, stb_th;
  logic [14:0] full_lvl;
  logic [7:0]  deb_cnt;

  // Trend history and debounce state.
  logic [14:0] lvl_ring[32];
  logic [31:0] time_ring[32];
  logic [4:0]  wr_ptr;
  int          n_entries;
  logic [31:0] last_ms;
  btps_pkg::pstate_t last_raw, held;
  int          repeats;

  reading_result_t results_due[$];

  function automatic reading_result_t predict_reading(logic [15:0] soc, logic [15:0] vcell,
                                                      logic [31:0] now);
    reading_result_t r;
    logic [14:0] lvl;
    logic [4:0]  newest, oldest, idx;
    logic [31:0] nt, ot, start, span;
    longint      diff, q;
    bit          trend;
    int          rate;
    btps_pkg::pstate_t raw;
    lvl = (soc > 16'd25600) ? 15'd25600 : soc[14:0];
    if (last_ms != 0 && now > last_ms && now - last_ms > gap_ms) begin
      wr_ptr = 0; n_entries = 0; last_raw = btps_pkg::PS_UNKNOWN; repeats = 0;
      held = btps_pkg::PS_UNKNOWN;
    end
    lvl_ring[wr_ptr] = lvl;
    time_ring[wr_ptr] = now;
    wr_ptr = wr_ptr + 5'd1;
    if (n_entries < 32) n_entries++;

    trend = 0;
    rate = 0;
    if (n_entries >= 2) begin
      newest = wr_ptr - 5'd1;
      nt = time_ring[newest];
      start = (nt >= window_ms) ? nt - window_ms : 32'd0;
      oldest = newest;
      for (int s = 1; s < n_entries; s++) begin
        idx = newest - 5'(s);
        if (time_ring[idx] < start) break;
        oldest = idx;
      end
      ot = time_ring[oldest];
      if (oldest != newest && nt > ot) begin
        span = nt - ot;
        if (span >= span_min_ms) begin
          diff = longint'(lvl_ring[newest]) - longint'(lvl_ring[oldest]);
          q = diff * 64'sd3600000 / longint'({32'd0, span});
          if (q > 1536000) q = 1536000;
          if (q < -1536000) q = -1536000;
          rate = int'(q);
          trend = 1;
        end
      end
    end

    if (trend && rate > chg_th) raw = btps_pkg::PS_CHARGING;
    else if (lvl >= full_lvl && rate >= stb_th) raw = btps_pkg::PS_FULL;
    else if (!trend) raw = btps_pkg::PS_UNKNOWN;
    else if (rate < dis_th) raw = btps_pkg::PS_DISCHARGING;
    else raw = btps_pkg::PS_UNKNOWN;

    if (raw != last_raw) begin
      last_raw = raw;
      repeats = 0;
    end
    if (repeats < 255) repeats++;
    if (repeats >= deb_cnt) held = raw;
    last_ms = now;

    r.level = lvl;
    r.vcell = vcell;
    r.rate = 22'(rate);
    r.pstate = held;
    r.ext_pwr = (held == btps_pkg::PS_CHARGING || held == btps_pkg::PS_FULL);
    return r;
  endfunction

  always @(posedge clk) begin
    reading_result_t want;
    if (!rst_n) begin
      window_ms <= 32'd120000; gap_ms <= 32'd90000; span_min_ms <= 32'd60000;
      chg_th <= 384; dis_th <= -128; stb_th <= -26;
      full_lvl <= 15'd25344; deb_cnt <= 8'd2;
      wr_ptr = 0; n_entries = 0; last_ms = 0;
      last_raw = btps_pkg::PS_UNKNOWN; held = btps_pkg::PS_UNKNOWN; repeats = 0;
      fail_count <= 0;
      results_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (btps_pkg::cfg_idx_t'(cfg_ch.index))
          btps_pkg::CFG_WINDOW: window_ms <= cfg_ch.data;
          btps_pkg::CFG_GAP:    gap_ms <= cfg_ch.data;
          btps_pkg::CFG_SPAN:   span_min_ms <= cfg_ch.data;
          btps_pkg::CFG_CHG_TH: chg_th <= int'($signed(cfg_ch.data[21:0]));
          btps_pkg::CFG_DIS_TH: dis_th <= int'($signed(cfg_ch.data[21:0]));
          btps_pkg::CFG_STB_TH: stb_th <= int'($signed(cfg_ch.data[21:0]));
          btps_pkg::CFG_FULL:   full_lvl <= cfg_ch.data[14:0];
          btps_pkg::CFG_DEB:    deb_cnt <= cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        results_due.push_back(predict_reading(in_ch.soc_raw, in_ch.vcell_raw, in_ch.now_ms));
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $error("result beat with no reading outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = results_due.pop_front();
          if (out_ch.charge_level !== want.level ||
              out_ch.cell_voltage !== want.vcell ||
              out_ch.charge_rate !== want.rate ||
              out_ch.power_state !== want.pstate ||
              out_ch.external_power !== want.ext_pwr)
            fail_count <= fail_count + 1;
          if (out_ch.charge_level !== want.level)
            $error("charge_level: expected %0d, got %0d", want.level, out_ch.charge_level);
          if (out_ch.cell_voltage !== want.vcell)
            $error("cell_voltage: expected %0d, got %0d", want.vcell, out_ch.cell_voltage);
          if (out_ch.charge_rate !== want.rate)
            $error("charge_rate: expected %0d, got %0d", want.rate, out_ch.charge_rate);
          if (out_ch.power_state !== want.pstate)
            $error("power_state: expected %0d, got %0d", want.pstate, out_ch.power_state);
          if (out_ch.external_power !== want.ext_pwr)
            $error("external_power: expected %0d, got %0d", want.ext_pwr,
                   out_ch.external_power);
        end
      end
    end
    pending = results_due.size();
  end
endmodule

// ===== dv/tb_top.sv =====
// Top of the testbench for the battery trend and power-state core: clock, reset, stimulus,
// configuration phases and the verdict. Depends on btps_pkg, btps_if, btps_checker and the core.
`timescale 1ns / 1ps
module tb_top;
  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  bit   no_idle;   // when set, neither side inserts gaps
  int   dt_max;    // largest step between timestamps in a well-formed sequence

  btps_in_if  in_ch();
  btps_out_if out_ch();
  btps_cfg_if cfg_ch();

  battery_trend_power_state_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  btps_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog. The slowest correct run is roughly 850 readings plus the pauses around
  // configuration; the limit is many times that.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 2000000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Unless no_idle is set, the result side stalls a freshly drawn number of cycles before each beat.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 13);
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Sends one reading beat after a random gap. Valid is left high afterwards, so a following
  // beat with no gap keeps it high without a lowering in between.
  task automatic send_reading(logic [15:0] soc, logic [15:0] vcell, logic [31:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.soc_raw <= soc;
    in_ch.vcell_raw <= vcell;
    in_ch.now_ms <= now;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic write_reg(btps_pkg::cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Registers change only with the core idle: every expected result is in, then a pause that
  // covers the latency of a reading still being worked on.
  task automatic settle;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] win, logic [31:0] gap, logic [31:0] span, int chg,
                           int dis, int stb, logic [14:0] full, logic [7:0] deb);
    settle();
    write_reg(btps_pkg::CFG_WINDOW, win);
    write_reg(btps_pkg::CFG_GAP, gap);
    write_reg(btps_pkg::CFG_SPAN, span);
    write_reg(btps_pkg::CFG_CHG_TH, 32'(chg));
    write_reg(btps_pkg::CFG_DIS_TH, 32'(dis));
    write_reg(btps_pkg::CFG_STB_TH, 32'(stb));
    write_reg(btps_pkg::CFG_FULL, 32'(full));
    write_reg(btps_pkg::CFG_DEB, 32'(deb));
  endtask

  // Mostly well-formed sequences: timestamps rising in steps of at most dt_max, with the
  // charge drifting up or down so that trends and every state are reached. The rest is
  // noise over the whole range of every field.
  task automatic random_readings(int count);
    int          sent;
    int          len;
    int          slope;
    int          lvl;
    logic [31:0] t;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 20) no_idle = ~no_idle;
      if ($urandom_range(0, 99) < 15) begin
        send_reading(16'($urandom), 16'($urandom), $urandom);
        sent++;
      end else begin
        len = $urandom_range(5, 40);
        t = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 1000000);
        lvl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                          : $urandom_range(0, 25600);
        slope = $urandom_range(0, 160) - 80;
        for (int i = 0; i < len && sent < count; i++) begin
          send_reading(16'(lvl), 16'($urandom), t);
          sent++;
          t = t + $urandom_range(1, dt_max);
          lvl = lvl + slope + $urandom_range(0, 20) - 10;
          if (lvl < 0) lvl = 0;
          if (lvl > 65535) lvl = 65535;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int lvl;
    no_idle = 1'b0;
    dt_max = 40000;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.soc_raw = '0;
    in_ch.vcell_raw = '0;
    in_ch.now_ms = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed readings under the reset settings: a missing timestamp, both field extremes, the
    // clamp just above full, time running backwards, a gap that clears the history, then
    // charging, discharging and full-connected runs.
    send_reading(16'd0, 16'd0, 32'd0);
    send_reading(16'hFFFF, 16'hFFFF, 32'd0);
    send_reading(16'd25600, 16'h5555, 32'd1000);
    send_reading(16'd25601, 16'hAAAA, 32'hFFFF_FFFF);
    send_reading(16'd12000, 16'd1, 32'd5000);
    for (int i = 0; i < 4; i++)
      send_reading(16'(10000 + 100 * i), 16'd3400, 32'(200000 + 30000 * i));
    for (int i = 0; i < 4; i++)
      send_reading(16'(10200 - 200 * i), 16'd3300, 32'(320000 + 30000 * i));
    for (int i = 0; i < 4; i++)
      send_reading(16'd25500, 16'd4200, 32'(440000 + 30000 * i));
    send_reading(16'd25500, 16'd4200, 32'd700000);
    send_reading(16'd0, 16'd4200, 32'd730000);
    send_reading(16'd25600, 16'd4200, 32'd790000);
    random_readings(200);

    // Smallest window, gap and span, with thresholds at the far ends: trends come only from
    // readings a millisecond apart and the rate saturates.
    configure(32'd1, 32'd1, 32'd1, -1536000, 1536000, -1536000, 15'd0, 8'd1);
    dt_max = 3;
    random_readings(200);

    // Largest window and gap with the longest debounce.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1536000, -1536000, 1536000, 15'd25600,
              8'd255);
    dt_max = 200000;
    lvl = 0;
    for (int i = 0; i < 3; i++) begin
      send_reading(16'(lvl), 16'd0, 32'(100 + i));
      lvl = lvl + 25600;
    end
    random_readings(200);

    // Middle settings with zero charge and discharge thresholds.
    configure(32'd60000, 32'd30000, 32'd5000, 0, 0, -1000, 15'd20000, 8'd3);
    dt_max = 20000;
    random_readings(200);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
